/* rtl/dlcar_pkg.sv */
package dlcar_pkg;

    // Field and register widths
    localparam int SAMPLE_W  = 16;
    localparam int LEN_W     = 13;
    localparam int CFG_IDX_W = 3;

    // Register indexes on the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE          = 3'd0,
        REG_DELAY_LENGTH  = 3'd1,
        REG_DRY_GAIN      = 3'd2,
        REG_WET_GAIN      = 3'd3,
        REG_FEEDBACK_GAIN = 3'd4
    } cfg_reg_t;

    // Reset values of the registers
    localparam logic                       MODE_RST     = 1'b0;
    localparam logic [LEN_W-1:0]           LENGTH_RST   = 13'd3528;
    localparam logic signed [SAMPLE_W-1:0] DRY_RST      = 16'sd19660;
    localparam logic signed [SAMPLE_W-1:0] WET_RST      = 16'sd13107;
    localparam logic signed [SAMPLE_W-1:0] FEEDBACK_RST = 16'sd26214;

    // 0.999 in Q15
    localparam logic signed [SAMPLE_W:0] Q15_0999 = 17'sd32735;

    localparam logic MODE_COMB    = 1'b0;
    localparam logic MODE_ALLPASS = 1'b1;

    // Current register contents
    typedef struct packed {
        logic                       mode;
        logic [LEN_W-1:0]           delay_length;
        logic signed [SAMPLE_W-1:0] dry_gain;
        logic signed [SAMPLE_W-1:0] wet_gain;
        logic signed [SAMPLE_W-1:0] feedback_gain;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_MUL4,
        ST_OUT
    } state_t;

    // Datapath operation for the current cycle
    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_READ,
        OP_MUL1,
        OP_MUL2,
        OP_MUL3,
        OP_MUL4
    } op_t;

    typedef struct packed {
        op_t  op;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic allpass;
    } dp_status_t;

    // Saturate a 17-bit signed value to 16 bits
    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SAMPLE_W:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v[SAMPLE_W] != v[SAMPLE_W-1]) begin
            r = v[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/dlcar_cfg.sv */
module dlcar_cfg
    import dlcar_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SAMPLE_W-1:0]  cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Register write decode; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_MODE:          cfg_next.mode          = cfg_data[0];
                REG_DELAY_LENGTH:  cfg_next.delay_length  = cfg_data[LEN_W-1:0];
                REG_DRY_GAIN:      cfg_next.dry_gain      = cfg_data;
                REG_WET_GAIN:      cfg_next.wet_gain      = cfg_data;
                REG_FEEDBACK_GAIN: cfg_next.feedback_gain = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode          <= MODE_RST;
            cfg_reg.delay_length  <= LENGTH_RST;
            cfg_reg.dry_gain      <= DRY_RST;
            cfg_reg.wet_gain      <= WET_RST;
            cfg_reg.feedback_gain <= FEEDBACK_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/dlcar_ctrl.sv */
module dlcar_ctrl
    import dlcar_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    assign m_tvalid = m_valid_reg;

    // Next state and datapath commands
    always_comb begin
        state_next   = state_reg;
        cmd.op       = OP_NONE;
        cmd.out_load = 1'b0;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.op = OP_CLEAR;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.op     = OP_READ;
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.op     = OP_MUL1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.op     = OP_MUL2;
                state_next = status.allpass ? ST_OUT : ST_MUL3;
            end
            ST_MUL3: begin
                cmd.op     = OP_MUL3;
                state_next = ST_MUL4;
            end
            ST_MUL4: begin
                cmd.op     = OP_MUL4;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output beat valid: set on load, cleared when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

/* rtl/dlcar_dp.sv */
module dlcar_dp
    import dlcar_pkg::*;
#(
    parameter int MAX_DELAY = 4096
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    input  logic [SAMPLE_W-1:0] s_tdata,
    output logic [SAMPLE_W-1:0] m_tdata
);

    localparam int AW = $clog2(MAX_DELAY);
    localparam int LW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;

    // Delay line storage
    logic signed [SAMPLE_W-1:0] mem [MAX_DELAY];

    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic signed [SAMPLE_W-1:0] rd_reg;
    logic signed [SAMPLE_W-1:0] acc_reg, acc_next;
    logic signed [SAMPLE_W-1:0] y_reg, y_next;
    logic [SAMPLE_W-1:0]        out_reg, out_next;
    logic signed [31:0]         prod_reg, prod_next;
    logic [AW-1:0]              ptr_reg, ptr_next;
    logic [AW-1:0]              wp_reg, wp_next;
    logic [AW-1:0]              clr_reg, clr_next;

    logic                       rd_en;
    logic                       prod_en;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic signed [SAMPLE_W-1:0] mem_wdata;
    logic signed [SAMPLE_W-1:0] mul_a, mul_b;
    logic signed [SAMPLE_W-1:0] q;
    logic signed [SAMPLE_W-1:0] s1;
    logic signed [SAMPLE_W-1:0] ng;
    logic signed [SAMPLE_W-1:0] store;
    logic signed [SAMPLE_W-1:0] y_sum;
    logic                       allpass;
    logic [LW-1:0]              len_raw, len_eff, wp_ext, ptr_inc;
    logic [AW-1:0]              ptr_eff, ptr_adv;

    assign allpass        = (cfg.mode == MODE_ALLPASS);
    assign status.allpass = allpass;
    assign status.clr_last = (clr_reg == AW'(MAX_DELAY - 1));
    assign m_tdata        = out_reg;

    // Effective length, clamped to 1..MAX_DELAY
    assign len_raw = LW'(cfg.delay_length);
    always_comb begin
        len_eff = len_raw;
        if (len_raw == '0) begin
            len_eff = LW'(1);
        end else if (len_raw > LW'(MAX_DELAY)) begin
            len_eff = LW'(MAX_DELAY);
        end
    end

    // Pointer taken as zero when the length was shortened below it
    assign wp_ext  = LW'(wp_reg);
    assign ptr_eff = (wp_ext >= len_eff) ? '0 : wp_reg;
    assign ptr_inc = LW'(ptr_reg) + LW'(1);
    assign ptr_adv = (ptr_inc >= len_eff) ? '0 : ptr_inc[AW-1:0];

    // Derived gains
    assign s1 = sat16(Q15_0999 - 17'(cfg.feedback_gain));
    assign ng = sat16(17'sd0 - 17'(cfg.feedback_gain));

    // Q15 result of last product: floor shift, then saturate
    assign q = sat16($signed(prod_reg[31:15]));

    // Saturated sums
    assign store = allpass ? sat16(17'(x_reg) + 17'(q)) : sat16(17'(acc_reg) + 17'(q));
    assign y_sum = sat16(17'(q) + 17'(rd_reg));

    assign prod_next = mul_a * mul_b;

    // Operation decode
    always_comb begin
        x_next    = x_reg;
        ptr_next  = ptr_reg;
        wp_next   = wp_reg;
        clr_next  = clr_reg;
        acc_next  = acc_reg;
        y_next    = y_reg;
        out_next  = out_reg;
        rd_en     = 1'b0;
        prod_en   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = ptr_reg;
        mem_wdata = store;
        mul_a     = x_reg;
        mul_b     = cfg.wet_gain;
        unique case (cmd.op)
            OP_NONE: ;
            OP_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + AW'(1);
            end
            OP_LOAD: begin
                x_next   = s_tdata;
                ptr_next = ptr_eff;
            end
            OP_READ: begin
                rd_en   = 1'b1;
                prod_en = 1'b1;
                mul_a   = x_reg;
                mul_b   = allpass ? ng : cfg.wet_gain;
            end
            OP_MUL1: begin
                prod_en = 1'b1;
                if (allpass) begin
                    y_next = y_sum;
                    mul_a  = rd_reg;
                    mul_b  = cfg.feedback_gain;
                end else begin
                    mul_a = q;
                    mul_b = s1;
                end
            end
            OP_MUL2: begin
                if (allpass) begin
                    mem_we  = 1'b1;
                    wp_next = ptr_adv;
                end else begin
                    acc_next = q;
                    prod_en  = 1'b1;
                    mul_a    = rd_reg;
                    mul_b    = cfg.feedback_gain;
                end
            end
            OP_MUL3: begin
                mem_we  = 1'b1;
                wp_next = ptr_adv;
                prod_en = 1'b1;
                mul_a   = x_reg;
                mul_b   = cfg.dry_gain;
            end
            OP_MUL4: begin
                y_next = y_sum;
            end
            default: ;
        endcase
        if (cmd.out_load) begin
            out_next = y_reg;
        end
    end

    // Delay memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_reg <= mem[ptr_reg];
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        ptr_reg <= ptr_next;
        acc_reg <= acc_next;
        y_reg   <= y_next;
        out_reg <= out_next;
        if (prod_en) begin
            prod_reg <= prod_next;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            clr_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            clr_reg <= clr_next;
        end
    end

endmodule

/* rtl/delay_line_comb_allpass_reverb_unit.sv */
// Channel   Direction  Handshake              Payload
// s_        in         s_tvalid / s_tready    s_tdata: sample_in
// m_        out        m_tvalid / m_tready    m_tdata: sample_out
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// From accept to result an allpass sample runs READ, MUL1, MUL2 and OUT,
// a comb sample also MUL3 and MUL4; the single shared 16x16 multiplier
// is used two or four times. After reset the delay memory is zeroed, one
// entry a cycle, MAX_DELAY entries (4096 by default) with s_tready low.
// The output register lets the next sample be accepted while a result
// beat waits; a held result stalls only the next sample's final step.
module delay_line_comb_allpass_reverb_unit
    import dlcar_pkg::*;
#(
    parameter int MAX_DELAY = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [SAMPLE_W-1:0]  s_tdata,   // [15:0] sample_in
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [SAMPLE_W-1:0]  m_tdata,   // [15:0] sample_out
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SAMPLE_W-1:0]  cfg_data
);

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    dlcar_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dlcar_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dlcar_dp #(
        .MAX_DELAY (MAX_DELAY)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .cmd     (cmd),
        .status  (status),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule

/* test/tb_delay_line_comb_allpass_reverb_unit.sv */
`timescale 1ns / 1ps

module tb_delay_line_comb_allpass_reverb_unit;
    import dlcar_pkg::*;

    localparam int DL_DEPTH    = 4096;
    localparam int CYCLE_LIMIT = 300000;
    // index past the last register, ignored by the block
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd5;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [SAMPLE_W-1:0]  s_tdata   = '0;   // [15:0] sample_in
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [SAMPLE_W-1:0]  m_tdata;          // [15:0] sample_out
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SAMPLE_W-1:0]  cfg_data  = '0;

    // register copies and delay line state of the predictor
    logic                       cur_mode;
    logic [LEN_W-1:0]           cur_len;
    logic signed [SAMPLE_W-1:0] cur_dry;
    logic signed [SAMPLE_W-1:0] cur_wet;
    logic signed [SAMPLE_W-1:0] cur_fb;
    logic signed [SAMPLE_W-1:0] echo_mem [0:DL_DEPTH-1];
    int                         echo_ptr;

    logic signed [SAMPLE_W-1:0] expected_samples [$];
    int error_count = 0;
    int cycle_count = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    logic rx_hold = 1'b0;

    delay_line_comb_allpass_reverb_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Saturating Q15 helpers
    function automatic int clip16(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // floor((a*b) / 2^15), saturated
    function automatic int q15_mul(input int a, input int b);
        int p;
        p = a * b;
        return clip16(p >>> 15);
    endfunction

    // One step of the reverb stage: returns the output sample, updates the line
    function automatic logic signed [SAMPLE_W-1:0] predict_reverb_sample(
        input logic signed [SAMPLE_W-1:0] x_in);
        int x, g, len, ptr, d, stored, y;
        x = x_in;
        g = cur_fb;
        len = cur_len;
        if (len == 0) len = 1;
        if (len > DL_DEPTH) len = DL_DEPTH;
        ptr = echo_ptr;
        // length was shortened below the pointer
        if (ptr >= len) ptr = 0;
        d = echo_mem[ptr];
        if (cur_mode == MODE_COMB) begin
            stored = clip16(q15_mul(q15_mul(x, cur_wet), clip16(Q15_0999 - g))
                            + q15_mul(d, g));
            y = clip16(q15_mul(x, cur_dry) + d);
        end else begin
            stored = clip16(x + q15_mul(d, g));
            y = clip16(q15_mul(x, clip16(-g)) + d);
        end
        echo_mem[ptr] = stored[SAMPLE_W-1:0];
        ptr++;
        if (ptr >= len) ptr = 0;
        echo_ptr = ptr;
        return y[SAMPLE_W-1:0];
    endfunction

    // Register write on the config channel, predictor copy updated on the beat
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_MODE:          cur_mode = val[0];
            REG_DELAY_LENGTH:  cur_len  = val[LEN_W-1:0];
            REG_DRY_GAIN:      cur_dry  = val;
            REG_WET_GAIN:      cur_wet  = val;
            REG_FEEDBACK_GAIN: cur_fb   = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Sends one sample beat; called and returns at a falling edge, tvalid left as is
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        do @(posedge aclk); while (!s_tready);
        expected_samples.push_back(predict_reverb_sample(x));
        @(negedge aclk);
    endtask

    task automatic tx_quiet();
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (expected_samples.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 15))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly short lines so they wrap often; upper data bits are don't-care
    function automatic logic [SAMPLE_W-1:0] pick_length_word();
        logic [2:0] hi;
        hi = 3'($urandom);
        case ($urandom_range(0, 11))
            0: return {hi, 13'd0};
            1: return {hi, 13'd1};
            2: return {hi, 13'd4096};
            3: return {hi, 13'h1FFF};
            default: return {hi, 13'($urandom_range(2, 40))};
        endcase
    endfunction

    // Warm-up with reset settings: line reads zero until it fills
    task automatic test_warmup_extremes();
        send_sample(16'sh7FFF);
        send_sample(-16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'sh0001);
        send_sample(-16'sh0001);
        send_sample(16'sh5555);
        tx_quiet();
        wait_drain();
    endtask

    // Most negative gains in both modes; length 1 with the pointer past it
    task automatic test_gain_extremes();
        write_reg(REG_DELAY_LENGTH, 16'd1);
        write_reg(REG_MODE, MODE_COMB);
        write_reg(REG_DRY_GAIN, 16'h8000);
        write_reg(REG_WET_GAIN, 16'h8000);
        write_reg(REG_FEEDBACK_GAIN, 16'h8000);
        send_sample(-16'sh8000);
        send_sample(-16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh0000);
        tx_quiet();
        wait_drain();
        write_reg(REG_MODE, MODE_ALLPASS);
        send_sample(-16'sh8000);
        send_sample(-16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh0001);
        tx_quiet();
        wait_drain();
    endtask

    // Length zero acts as one, lengths past the depth clamp to it
    task automatic test_length_limits();
        write_reg(REG_DELAY_LENGTH, 16'hE000);
        write_reg(CFG_IDX_SPARE, 16'hA5A5);
        write_reg(REG_FEEDBACK_GAIN, 16'h7FFF);
        send_sample(16'sh7FFF);
        send_sample(-16'sh2AAB);
        send_sample(16'sh1234);
        tx_quiet();
        wait_drain();
        write_reg(REG_DELAY_LENGTH, 16'hFFFF);
        write_reg(REG_MODE, MODE_COMB);
        write_reg(REG_DRY_GAIN, 16'h7FFF);
        write_reg(REG_WET_GAIN, 16'h7FFF);
        send_sample(-16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(-16'sh0001);
        tx_quiet();
        wait_drain();
    endtask

    // Receiver holds off for a long stretch while samples keep coming
    task automatic test_backpressure();
        write_reg(REG_MODE, MODE_ALLPASS);
        write_reg(REG_DELAY_LENGTH, 16'd16);
        write_reg(REG_FEEDBACK_GAIN, pick_gain());
        rx_hold = 1'b1;
        fork
            begin
                int held;
                held = 0;
                while (held < 400) begin
                    @(posedge aclk);
                    held++;
                end
                rx_hold = 1'b0;
            end
            begin
                repeat (40) send_sample(pick_sample());
            end
        join
        tx_quiet();
        wait_drain();
    endtask

    // Random settings, then random samples under the given idling
    task automatic test_random_phase(input int tx_pct, input int rx_pct, input int n_items);
        write_reg(REG_MODE, 16'($urandom_range(0, 1)) | (16'($urandom) & 16'hFFFE));
        write_reg(REG_DELAY_LENGTH, pick_length_word());
        write_reg(REG_DRY_GAIN, pick_gain());
        write_reg(REG_WET_GAIN, pick_gain());
        write_reg(REG_FEEDBACK_GAIN, pick_gain());
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (n_items) send_sample(pick_sample());
        tx_quiet();
        wait_drain();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
    endtask

    // Receiver ready, driven on the falling edge
    always @(negedge aclk) begin
        m_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Result checker
    always @(posedge aclk) begin : check_results
        logic signed [SAMPLE_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_samples.size() == 0) begin
                $error("sample_out: unexpected beat, actual %0d", $signed(m_tdata));
                error_count++;
            end else begin
                want = expected_samples.pop_front();
                if (m_tdata !== want) begin
                    $error("sample_out: expected %0d, actual %0d", want, $signed(m_tdata));
                    error_count++;
                end
            end
        end
    end

    // Run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        cur_mode = MODE_RST;
        cur_len  = LENGTH_RST;
        cur_dry  = DRY_RST;
        cur_wet  = WET_RST;
        cur_fb   = FEEDBACK_RST;
        echo_ptr = 0;
        for (int i = 0; i < DL_DEPTH; i++) echo_mem[i] = '0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_warmup_extremes();
        test_gain_extremes();
        test_length_limits();
        test_backpressure();
        test_random_phase(0, 0, 125);
        test_random_phase(71, 0, 125);
        test_random_phase(0, 71, 125);
        test_random_phase(6, 6, 125);
        test_random_phase(0, 0, 125);
        test_random_phase(71, 0, 125);
        test_random_phase(0, 71, 125);
        test_random_phase(6, 6, 125);

        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/dlcar_pkg.sv
rtl/dlcar_cfg.sv
rtl/dlcar_ctrl.sv
rtl/dlcar_dp.sv
rtl/delay_line_comb_allpass_reverb_unit.sv
test/tb_delay_line_comb_allpass_reverb_unit.sv
